[rtl/utf8d_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_pkg
// Types and constants shared by the UTF-8 stream decoder modules.
// ----------------------------------------------------------------------------
package utf8d_pkg;

	localparam int unsigned CpW  = 31;
	localparam int unsigned RemW = 3;

	// result status codes
	typedef enum logic [1:0] {
		ST_CHAR = 2'd0,
		ST_ERR  = 2'd1,
		ST_EOI  = 2'd2
	} status_t;

	// decoder state carried from one byte to the next
	typedef struct packed {
		logic [CpW-1:0]  partial;
		logic [RemW-1:0] remaining;
	} dec_state_t;

	// one result request
	typedef struct packed {
		logic           vld;
		logic [CpW-1:0] code_point;
		status_t        status;
	} dec_result_t;

	localparam logic [CpW-1:0] MaxCpReset   = 31'h0010FFFF;
	localparam logic [CpW-1:0] SurrogateLo  = 31'h0000D800;
	localparam logic [CpW-1:0] SurrogateHi  = 31'h0000DFFF;
	localparam logic [CpW-1:0] NoncharLo    = 31'h0000FDD0;
	localparam logic [CpW-1:0] NoncharHi    = 31'h0000FDEF;
	localparam logic [14:0]    NoncharPlane = 15'h7FFF;

endpackage
`default_nettype wire

[rtl/utf8d_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_step
// Combinational decode of one byte against the current decoder state.
// ----------------------------------------------------------------------------
module utf8d_step (
	input  wire logic [7:0]                 data_byte,
	input  wire logic                       end_of_input,
	input  wire logic [utf8d_pkg::CpW-1:0]  max_cp,
	input  wire utf8d_pkg::dec_state_t      cur,
	output utf8d_pkg::dec_state_t           nxt,
	output utf8d_pkg::dec_result_t          res
);
	import utf8d_pkg::*;

	logic [RemW-1:0] lead_rem;
	logic            lead_bad;
	logic            lead_single;
	logic [CpW-1:0]  lead_val;
	logic [CpW-1:0]  shifted;
	logic [RemW-1:0] rem_dec;
	logic            value_ok;

	// lead byte classification: continuation bytes still to come and value bits
	always_comb begin
		lead_rem    = '0;
		lead_bad    = 1'b0;
		lead_single = 1'b0;
		lead_val    = '0;
		if (data_byte[7] == 1'b0) begin
			lead_single = 1'b1;
			lead_val    = {23'd0, data_byte};
		end else if (data_byte[7:6] == 2'b10) begin
			lead_bad = 1'b1;
		end else if (data_byte[7:5] == 3'b110) begin
			lead_rem = 3'd1;
			lead_val = {26'd0, data_byte[4:0]};
		end else if (data_byte[7:4] == 4'b1110) begin
			lead_rem = 3'd2;
			lead_val = {27'd0, data_byte[3:0]};
		end else if (data_byte[7:3] == 5'b11110) begin
			lead_rem = 3'd3;
			lead_val = {28'd0, data_byte[2:0]};
		end else if (data_byte[7:2] == 6'b111110) begin
			lead_rem = 3'd4;
			lead_val = {29'd0, data_byte[1:0]};
		end else if (data_byte[7:1] == 7'b1111110) begin
			lead_rem = 3'd5;
			lead_val = {30'd0, data_byte[0]};
		end else begin
			lead_bad = 1'b1;
		end
	end

	// continuation shift-in and completion checks
	assign shifted = {cur.partial[CpW-7:0], data_byte[5:0]};
	assign rem_dec = cur.remaining - 3'd1;
	assign value_ok = (shifted <= max_cp)
		&& (shifted[15:1] != NoncharPlane)
		&& !(shifted inside {[SurrogateLo:SurrogateHi]})
		&& !(shifted inside {[NoncharLo:NoncharHi]});

	// next state and result
	always_comb begin
		nxt            = cur;
		res.vld        = 1'b0;
		res.code_point = '0;
		res.status     = ST_CHAR;
		if (cur.remaining == '0) begin
			if (end_of_input) begin
				res.vld    = 1'b1;
				res.status = ST_EOI;
			end else if (lead_bad) begin
				nxt        = '0;
				res.vld    = 1'b1;
				res.status = ST_ERR;
			end else if (lead_single) begin
				nxt.partial    = '0;
				res.vld        = 1'b1;
				res.code_point = lead_val;
			end else begin
				nxt.partial   = lead_val;
				nxt.remaining = lead_rem;
			end
		end else if (end_of_input || data_byte[7:6] != 2'b10) begin
			nxt        = '0;
			res.vld    = 1'b1;
			res.status = ST_ERR;
		end else if (rem_dec != '0) begin
			nxt.partial   = shifted;
			nxt.remaining = rem_dec;
		end else if (!value_ok) begin
			nxt        = '0;
			res.vld    = 1'b1;
			res.status = ST_ERR;
		end else begin
			nxt            = '0;
			res.vld        = 1'b1;
			res.code_point = shifted;
		end
	end

endmodule
`default_nettype wire

[rtl/utf8d_out_reg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_out_reg
// Result register toward the consumer, with valid and stall.
// ----------------------------------------------------------------------------
module utf8d_out_reg (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      load,
	input  wire utf8d_pkg::dec_result_t    res,
	output logic                           free,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [utf8d_pkg::CpW-1:0]      code_point,
	output logic [1:0]                     status
);
	import utf8d_pkg::*;

	logic           vld_q;
	logic [CpW-1:0] cp_q;
	status_t        st_q;

	// register can take a new request when empty or being drained
	assign free = !vld_q || !out_stall;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (free) begin
			vld_q <= load;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (free && load) begin
			cp_q <= res.code_point;
			st_q <= res.status;
		end
	end

	assign out_valid  = vld_q;
	assign code_point = cp_q;
	assign status     = st_q;

endmodule
`default_nettype wire

[rtl/utf8_stream_decoder_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// Streaming UTF-8 decoder, one byte or end-of-input mark per request.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while in_stall is low. An accepted request lands
// in an input register; once the output register can take it, it is decoded
// against the held partial value and continuation count and any result goes
// into the output register, so a result passes through the input register
// and the output register. The decode step is a single shift-or plus range
// compares, so the rate is one request per cycle whenever the consumer does
// not stall. Lead bytes of multi-byte sequences and interior continuation
// bytes produce no result. Writes to max_code_point are taken at any time
// (cfg_ready is always high) and must be made while idle.
module utf8_stream_decoder_unit (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [7:0]                data_byte,
	input  wire logic                      end_of_input,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [utf8d_pkg::CpW-1:0]      code_point,
	output logic [1:0]                     status,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [utf8d_pkg::CpW-1:0] max_code_point
);
	import utf8d_pkg::*;

	logic           vld_s1;
	logic [7:0]     byte_s1;
	logic           eoi_s1;
	logic [CpW-1:0] max_cp_q;
	dec_state_t     state_q;
	dec_state_t     state_nxt;
	dec_result_t    res;
	logic           out_free;
	logic           process;

	assign cfg_ready = 1'b1;

	// the held byte is decoded once the result register can take it
	assign process  = vld_s1 && out_free;
	assign in_stall = vld_s1 && !out_free;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_cp_q <= MaxCpReset;
		end else if (cfg_valid && cfg_ready) begin
			max_cp_q <= max_code_point;
		end
	end

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			eoi_s1  <= end_of_input;
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (process) begin
			state_q <= state_nxt;
		end
	end

	utf8d_step u_step (
		.data_byte    (byte_s1),
		.end_of_input (eoi_s1),
		.max_cp       (max_cp_q),
		.cur          (state_q),
		.nxt          (state_nxt),
		.res          (res)
	);

	utf8d_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (process && res.vld),
		.res        (res),
		.free       (out_free),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.code_point (code_point),
		.status     (status)
	);

	// stall is only raised while a byte is held
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> vld_s1)
		else $error("input stalled with empty input stage");

	// error and end-of-input results carry a zero code point
	a_cp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_CHAR) |-> (code_point == '0))
		else $error("non-character result with nonzero code point");

	// continuation count never exceeds the longest sequence
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.remaining <= 3'd5)
		else $error("continuation count out of range");

	// an error clears the open sequence
	a_err_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(process && res.vld && res.status == ST_ERR) |=>
		(state_q == '0))
		else $error("state not cleared after error");

endmodule
`default_nettype wire
